// ===== sv/tcg_pkg.sv =====
// Shared types, codes and default sizes of the text character generator.
`default_nettype none

package tcg_pkg;

	// Default glyph geometry and font size.
	localparam int DEF_CHAR_WIDTH  = 6;
	localparam int DEF_CHAR_HEIGHT = 12;
	localparam int DEF_GLYPH_COUNT = 256;

	localparam int COORD_W = 10;
	localparam int COLOR_W = 16;
	localparam int FIDX_W  = 11;

	// Operation codes.
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_CHAR   = 2'd1;
	localparam logic [1:0] OP_CURSOR = 2'd2;

	// Character codes with a meaning of their own.
	localparam logic [7:0] CODE_BS  = 8'h08;
	localparam logic [7:0] CODE_LF  = 8'h0A;
	localparam logic [7:0] CODE_CR  = 8'h0D;
	localparam logic [7:0] BLOCK_LO = 8'h80;
	localparam logic [7:0] BLOCK_HI = 8'hBF;

	// Configuration register indexes.
	typedef logic [2:0] cfg_addr_t;
	localparam cfg_addr_t REG_FG_COLOR      = 3'd0;
	localparam cfg_addr_t REG_BG_COLOR      = 3'd1;
	localparam cfg_addr_t REG_WRAP_ENABLE   = 3'd2;
	localparam cfg_addr_t REG_SCREEN_WIDTH  = 3'd3;
	localparam cfg_addr_t REG_SCREEN_HEIGHT = 3'd4;

	typedef struct packed {
		logic [1:0]         operation;
		logic [FIDX_W-1:0]  font_index;
		logic [7:0]         font_byte;
		logic [7:0]         char_code;
		logic [COORD_W-1:0] cursor_x_in;
		logic [COORD_W-1:0] cursor_y_in;
	} cmd_item_t;

	typedef struct packed {
		logic [COORD_W-1:0] column_x;
		logic [COORD_W-1:0] column_y;
		logic [15:0]        pixel_mask;
		logic [COLOR_W-1:0] on_color;
		logic [COLOR_W-1:0] off_color;
		logic               last_column;
	} res_item_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic take;       // latch the incoming item
		logic exec;       // font load, cursor set or control character
		logic col_clear;  // restart the column counter
		logic col_step;   // move to the next column
		logic emit;       // load the result register
		logic advance;    // step the cursor past a printed character
	} ctrl_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic print_char;
		logic visible;
		logic last_col;
		logic res_free;
	} ctrl_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// ===== sv/tcg_ctrl.sv =====
// Sequencer of the text character generator: accept, decode, emit columns.
`default_nettype none

module tcg_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_valid,
	output logic                       cmd_stall,
	input  wire tcg_pkg::ctrl_status_t sts,
	output tcg_pkg::ctrl_cmd_t         ctl
);
	import tcg_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		cmd_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					ctl.take = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.print_char && sts.visible) begin
					ctl.col_clear = 1'b1;
					state_d       = ST_EMIT;
				end else if (sts.print_char) begin
					ctl.advance = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					ctl.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (sts.res_free) begin
					ctl.emit = 1'b1;
					if (sts.last_col) begin
						ctl.advance = 1'b1;
						state_d     = ST_IDLE;
					end else begin
						ctl.col_step = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/tcg_dp.sv =====
// Datapath: config registers, cursor, font store, column mask and result register.
`default_nettype none

module tcg_dp #(
	parameter int CHAR_WIDTH  = tcg_pkg::DEF_CHAR_WIDTH,
	parameter int CHAR_HEIGHT = tcg_pkg::DEF_CHAR_HEIGHT,
	parameter int GLYPH_COUNT = tcg_pkg::DEF_GLYPH_COUNT
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tcg_pkg::cmd_item_t  cmd,
	input  wire logic                cfg_we,
	input  wire tcg_pkg::cfg_addr_t  cfg_addr,
	input  wire logic [15:0]         cfg_data,
	input  wire tcg_pkg::ctrl_cmd_t  ctl,
	output tcg_pkg::ctrl_status_t    sts,
	input  wire logic                res_stall,
	output logic                     res_valid,
	output tcg_pkg::res_item_t       res
);
	import tcg_pkg::*;

	localparam int STORE_SIZE = GLYPH_COUNT * CHAR_WIDTH;
	localparam int ADDR_W     = $clog2(STORE_SIZE);
	localparam int COL_W      = (CHAR_WIDTH > 1) ? $clog2(CHAR_WIDTH) : 1;
	localparam logic [7:0] LOW_ROWS = 8'((1 << (CHAR_HEIGHT - 8)) - 1);
	localparam logic [COORD_W:0] COORD_MAX = (COORD_W+1)'((1 << COORD_W) - 1);

	function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W:0] s);
		return (s > COORD_MAX) ? COORD_MAX[COORD_W-1:0] : s[COORD_W-1:0];
	endfunction

	// Config registers.
	logic [COLOR_W-1:0] fg_q, bg_q;
	logic               wrap_q;
	logic [COORD_W-1:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q     <= '1;
			bg_q     <= '0;
			wrap_q   <= 1'b1;
			width_q  <= COORD_W'(320);
			height_q <= COORD_W'(240);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_FG_COLOR:      fg_q     <= cfg_data;
				REG_BG_COLOR:      bg_q     <= cfg_data;
				REG_WRAP_ENABLE:   wrap_q   <= cfg_data[0];
				REG_SCREEN_WIDTH:  width_q  <= cfg_data[COORD_W-1:0];
				REG_SCREEN_HEIGHT: height_q <= cfg_data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	// Item register.
	cmd_item_t cmd_q;

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			cmd_q <= cmd;
		end
	end

	logic is_ctrl_code, glyph_ok, is_block, idx_ok;
	assign is_ctrl_code = (cmd_q.char_code == CODE_LF) || (cmd_q.char_code == CODE_CR)
		|| (cmd_q.char_code == CODE_BS);
	assign glyph_ok = {1'b0, cmd_q.char_code} < 9'(GLYPH_COUNT);
	assign is_block = cmd_q.char_code inside {[BLOCK_LO:BLOCK_HI]};
	assign idx_ok   = {1'b0, cmd_q.font_index} < (FIDX_W+1)'(STORE_SIZE);

	// Column counter.
	logic [COL_W-1:0] col_q, col_d;

	always_comb begin
		col_d = col_q;
		if (ctl.col_clear) begin
			col_d = '0;
		end else if (ctl.col_step) begin
			col_d = col_q + COL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else begin
			col_q <= col_d;
		end
	end

	// Font store: read every cycle at the column the counter moves to.
	logic [7:0]        store [STORE_SIZE];
	logic [7:0]        rd_q;
	logic [FIDX_W-1:0] rd_addr;

	assign rd_addr = glyph_ok
		? FIDX_W'(cmd_q.char_code) * FIDX_W'(CHAR_WIDTH) + FIDX_W'(col_d)
		: '0;

	always_ff @(posedge clk) begin
		if (ctl.exec && cmd_q.operation == OP_LOAD && idx_ok) begin
			store[cmd_q.font_index[ADDR_W-1:0]] <= cmd_q.font_byte;
		end
		rd_q <= store[rd_addr[ADDR_W-1:0]];
	end

	// Cursor.
	logic [COORD_W-1:0] cur_x_q, cur_y_q, cur_x_d, cur_y_d;
	logic [COORD_W-1:0] adv_x, y_down;

	assign adv_x  = sat_coord({1'b0, cur_x_q} + (COORD_W+1)'(CHAR_WIDTH));
	assign y_down = sat_coord({1'b0, cur_y_q} + (COORD_W+1)'(CHAR_HEIGHT));

	always_comb begin
		cur_x_d = cur_x_q;
		cur_y_d = cur_y_q;
		if (ctl.exec) begin
			case (cmd_q.operation)
				OP_CURSOR: begin
					cur_x_d = cmd_q.cursor_x_in;
					cur_y_d = cmd_q.cursor_y_in;
				end
				OP_CHAR: begin
					if (cmd_q.char_code == CODE_LF) begin
						cur_x_d = '0;
						cur_y_d = y_down;
					end else if (cmd_q.char_code == CODE_BS) begin
						if (cur_x_q >= COORD_W'(CHAR_WIDTH)) begin
							cur_x_d = cur_x_q - COORD_W'(CHAR_WIDTH);
						end else begin
							cur_x_d = '0;
							cur_y_d = (cur_y_q >= COORD_W'(CHAR_HEIGHT))
								? cur_y_q - COORD_W'(CHAR_HEIGHT) : '0;
						end
					end
				end
				default: ;
			endcase
		end else if (ctl.advance) begin
			if (wrap_q && ({2'b0, adv_x} + (COORD_W+2)'(CHAR_WIDTH)
				> {2'b0, width_q})) begin
				cur_x_d = '0;
				cur_y_d = y_down;
			end else begin
				cur_x_d = adv_x;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
		end else begin
			cur_x_q <= cur_x_d;
			cur_y_q <= cur_y_d;
		end
	end

	// Column mask.
	logic [7:0]  bits;
	logic [15:0] mask;

	assign bits = glyph_ok ? rd_q : 8'h00;

	always_comb begin
		if (is_block) begin
			mask = {(bits[7] ? LOW_ROWS : 8'h00),
				bits[5], bits[4], bits[4], bits[3], bits[2], bits[2], bits[1], bits[0]};
		end else begin
			mask = {8'h00, bits};
		end
	end

	// Result register.
	logic      res_valid_q;
	res_item_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			res_q.column_x    <= sat_coord({1'b0, cur_x_q} + (COORD_W+1)'(col_q));
			res_q.column_y    <= cur_y_q;
			res_q.pixel_mask  <= mask;
			res_q.on_color    <= fg_q;
			res_q.off_color   <= (bg_q == fg_q) ? '0 : bg_q;
			res_q.last_column <= sts.last_col;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign sts.print_char = (cmd_q.operation == OP_CHAR) && !is_ctrl_code;
	assign sts.visible    = (cur_x_q < width_q) && (cur_y_q < height_q);
	assign sts.last_col   = col_q == COL_W'(CHAR_WIDTH - 1);
	assign sts.res_free   = !res_valid_q || !res_stall;

endmodule

`default_nettype wire

// ===== sv/text_character_generator.sv =====
// Top level of the text character generator: sequencer plus datapath.
// A printable, visible character is taken while idle, then decoded, then emitted column
//   by column, one column per cycle unless the result side stalls, from the single read
//   port of the font store; no new item is taken until the sequencer is idle again.
// Reset: arst_n clears the cursor, the sequencer and the result register, and loads
//   the config defaults; the font store is not cleared and must be loaded before use.
`default_nettype none

module text_character_generator #(
	parameter int CHAR_WIDTH  = tcg_pkg::DEF_CHAR_WIDTH,
	parameter int CHAR_HEIGHT = tcg_pkg::DEF_CHAR_HEIGHT,
	parameter int GLYPH_COUNT = tcg_pkg::DEF_GLYPH_COUNT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Command items
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire tcg_pkg::cmd_item_t cmd,
	// Column result items
	output logic                    res_valid,
	input  wire logic               res_stall,
	output tcg_pkg::res_item_t      res,
	// Register writes
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire tcg_pkg::cfg_addr_t cfg_addr,
	input  wire logic [15:0]        cfg_data
);
	import tcg_pkg::*;

	ctrl_cmd_t    ctl;
	ctrl_status_t sts;

	// Registers may be written at any time; the user writes them only while idle.
	assign cfg_ready = 1'b1;

	// Sequencer: idle -> decode -> (emit columns) -> idle.
	tcg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	// Datapath: holds the item, the cursor, the font store and the result register.
	tcg_dp #(
		.CHAR_WIDTH  (CHAR_WIDTH),
		.CHAR_HEIGHT (CHAR_HEIGHT),
		.GLYPH_COUNT (GLYPH_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.sts       (sts),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule

`default_nettype wire

// ===== sv/tcg_checker.sv =====
// Port-level checks of the text character generator, bound to the top level.
`default_nettype none

module tcg_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               cmd_valid,
	input wire logic               cmd_stall,
	input wire logic               res_valid,
	input wire logic               res_stall,
	input wire tcg_pkg::res_item_t res
);
	import tcg_pkg::*;

	// A stalled result holds.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

	// One item at a time: an accepted item blocks the next one.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("item accepted while another is in work");

	// While a column other than the last is shown, the character is still in work.
	a_mid_char: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last_column |-> cmd_stall)
		else $error("input opened in the middle of a character");

	// A new result only comes out of column emission.
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cmd_stall))
		else $error("result appeared without a character in work");

endmodule

bind text_character_generator tcg_checker u_tcg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

`default_nettype wire

// ===== verif/tcg_column_checker.sv =====
`timescale 1ns / 100ps
// Column checker for the text character generator: predicts glyph columns and compares them.

module tcg_column_checker #(
	parameter int CHAR_WIDTH  = tcg_pkg::DEF_CHAR_WIDTH,
	parameter int CHAR_HEIGHT = tcg_pkg::DEF_CHAR_HEIGHT,
	parameter int GLYPH_COUNT = tcg_pkg::DEF_GLYPH_COUNT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_stall,
	input  tcg_pkg::cmd_item_t cmd,
	input  logic               res_valid,
	input  logic               res_stall,
	input  tcg_pkg::res_item_t res,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  tcg_pkg::cfg_addr_t cfg_addr,
	input  logic [15:0]        cfg_data,
	output int                 mismatches,
	output int                 pending
);
	import tcg_pkg::*;

	localparam int STORE_DEPTH = GLYPH_COUNT * CHAR_WIDTH;
	localparam int COORD_MAX   = 1023;
	localparam int PRINT_CAP   = 100;

	logic [15:0] fg_color;
	logic [15:0] bg_color;
	logic        wrap_on;
	int          screen_w;
	int          screen_h;
	int          cur_x;
	int          cur_y;
	logic [7:0]  glyph_bytes [STORE_DEPTH];
	res_item_t   expected_columns [$];
	int          mismatch_count = 0;
	int          columns_waiting = 0;

	assign mismatches = mismatch_count;
	assign pending    = columns_waiting;

	function automatic int sat_coord(input int v);
		return (v > COORD_MAX) ? COORD_MAX : v;
	endfunction

	// Map one stored font byte to the rows of a glyph column.
	function automatic logic [15:0] column_rows(input logic [7:0] code, input logic [7:0] bits);
		logic [15:0] m;
		m = '0;
		if (code >= BLOCK_LO && code <= BLOCK_HI) begin
			m[0] = bits[0];
			m[1] = bits[1];
			m[2] = bits[2];
			m[3] = bits[2];
			m[4] = bits[3];
			m[5] = bits[4];
			m[6] = bits[4];
			m[7] = bits[5];
			for (int r = 8; r < CHAR_HEIGHT && r < 16; r++)
				m[r] = bits[7];
		end else begin
			m[7:0] = bits;
		end
		return m;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("%0t: %s", $time, msg);
	endtask

	task automatic apply_register(input cfg_addr_t idx, input logic [15:0] value);
		case (idx)
			REG_FG_COLOR:      fg_color = value;
			REG_BG_COLOR:      bg_color = value;
			REG_WRAP_ENABLE:   wrap_on  = value[0];
			REG_SCREEN_WIDTH:  screen_w = int'(value[9:0]);
			REG_SCREEN_HEIGHT: screen_h = int'(value[9:0]);
			default: ;
		endcase
	endtask

	task automatic predict_columns(input cmd_item_t c);
		res_item_t   col;
		logic [7:0]  bits;
		logic [15:0] off_c;
		int          addr;
		case (c.operation)
			OP_LOAD: begin
				if (int'(c.font_index) < STORE_DEPTH)
					glyph_bytes[c.font_index] = c.font_byte;
			end
			OP_CURSOR: begin
				cur_x = int'(c.cursor_x_in);
				cur_y = int'(c.cursor_y_in);
			end
			OP_CHAR: begin
				if (c.char_code == CODE_LF) begin
					cur_y = sat_coord(cur_y + CHAR_HEIGHT);
					cur_x = 0;
				end else if (c.char_code == CODE_CR) begin
				end else if (c.char_code == CODE_BS) begin
					if (cur_x >= CHAR_WIDTH) begin
						cur_x = cur_x - CHAR_WIDTH;
					end else begin
						cur_x = 0;
						cur_y = (cur_y >= CHAR_HEIGHT) ? cur_y - CHAR_HEIGHT : 0;
					end
				end else begin
					if (cur_x < screen_w && cur_y < screen_h) begin
						off_c = (bg_color == fg_color) ? 16'h0000 : bg_color;
						for (int i = 0; i < CHAR_WIDTH; i++) begin
							bits = 8'h00;
							addr = int'(c.char_code) * CHAR_WIDTH + i;
							if (int'(c.char_code) < GLYPH_COUNT && addr < STORE_DEPTH)
								bits = glyph_bytes[addr];
							col.column_x    = 10'(sat_coord(cur_x + i));
							col.column_y    = 10'(cur_y);
							col.pixel_mask  = column_rows(c.char_code, bits);
							col.on_color    = fg_color;
							col.off_color   = off_c;
							col.last_column = (i == CHAR_WIDTH - 1);
							expected_columns.push_back(col);
						end
					end
					cur_x = sat_coord(cur_x + CHAR_WIDTH);
					if (wrap_on && cur_x > screen_w - CHAR_WIDTH) begin
						cur_y = sat_coord(cur_y + CHAR_HEIGHT);
						cur_x = 0;
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_column(input res_item_t got);
		res_item_t exp;
		string     diffs;
		diffs = "";
		if (expected_columns.size() == 0) begin
			report_mismatch($sformatf("column at x %0d y %0d with none expected",
				got.column_x, got.column_y));
		end else begin
			exp = expected_columns.pop_front();
			if (got.column_x !== exp.column_x)
				diffs = {diffs, $sformatf(" column_x %0d/%0d", got.column_x, exp.column_x)};
			if (got.column_y !== exp.column_y)
				diffs = {diffs, $sformatf(" column_y %0d/%0d", got.column_y, exp.column_y)};
			if (got.pixel_mask !== exp.pixel_mask)
				diffs = {diffs, $sformatf(" pixel_mask %h/%h", got.pixel_mask, exp.pixel_mask)};
			if (got.on_color !== exp.on_color)
				diffs = {diffs, $sformatf(" on_color %h/%h", got.on_color, exp.on_color)};
			if (got.off_color !== exp.off_color)
				diffs = {diffs, $sformatf(" off_color %h/%h", got.off_color, exp.off_color)};
			if (got.last_column !== exp.last_column)
				diffs = {diffs, $sformatf(" last_column %b/%b", got.last_column, exp.last_column)};
			if (diffs != "")
				report_mismatch({"column mismatch (got/exp):", diffs});
		end
	endtask

	// Results first: a column leaving at this edge never belongs to a command taken here.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_color = 16'hFFFF;
			bg_color = 16'h0000;
			wrap_on  = 1'b1;
			screen_w = 320;
			screen_h = 240;
			cur_x    = 0;
			cur_y    = 0;
			expected_columns.delete();
			columns_waiting <= 0;
		end else begin
			if (res_valid && !res_stall)
				check_column(res);
			if (cfg_valid && cfg_ready)
				apply_register(cfg_addr, cfg_data);
			if (cmd_valid && !cmd_stall)
				predict_columns(cmd);
			columns_waiting <= expected_columns.size();
		end
	end

endmodule

// ===== verif/tb_text_character_generator.sv =====
`timescale 1ns / 100ps
// Testbench top for the text character generator: stimulus, stalls and verdict.

module tb_text_character_generator;
	import tcg_pkg::*;

	localparam int CHAR_WIDTH    = DEF_CHAR_WIDTH;
	localparam int STORE_DEPTH   = DEF_GLYPH_COUNT * DEF_CHAR_WIDTH;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASE_ITEMS   = 25;
	// Operation code the block leaves unused.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_stall;
	cmd_item_t   cmd;
	logic        res_valid;
	logic        res_stall;
	res_item_t   res;
	logic        cfg_valid;
	logic        cfg_ready;
	cfg_addr_t   cfg_addr;
	logic [15:0] cfg_data;

	int          column_failures;
	int          columns_pending;
	int          sender_idle_pct = 0;
	int          receiver_stall_pct = 0;
	int          items_counted = 0;
	int          screen_w = 320;
	int          screen_h = 240;
	// Codes whose every font column has been loaded; only these get printed.
	logic [7:0]  loaded_codes [$];
	bit          code_listed [0:255];

	text_character_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	tcg_column_checker u_column_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_addr   (cfg_addr),
		.cfg_data   (cfg_data),
		.mismatches (column_failures),
		.pending    (columns_pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#4_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Stall the column side at the rate of the current phase.
	always @(posedge clk)
		res_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);

	// Start from a fully random item so that unused fields toggle too.
	function automatic cmd_item_t random_cmd(input logic [1:0] op);
		logic [63:0] r;
		cmd_item_t   c;
		r = {$urandom, $urandom};
		c = r[$bits(cmd_item_t)-1:0];
		c.operation = op;
		return c;
	endfunction

	// Favor zero, the top of the range and the area just below a screen limit.
	function automatic int pick_coord(input int limit_pos);
		int v;
		case ($urandom_range(4))
			0: return 0;
			1: return 1023;
			2: begin
				v = limit_pos - int'($urandom_range(7));
				return (v < 0) ? 0 : v;
			end
			default: return int'($urandom_range(1023));
		endcase
	endfunction

	function automatic logic [7:0] pick_glyph_code();
		logic [7:0] picks [6] = '{8'h00, 8'h7F, BLOCK_LO, BLOCK_HI, 8'hC0, 8'hFF};
		if ($urandom_range(9) < 4)
			return picks[$urandom_range(5)];
		return 8'($urandom_range(255));
	endfunction

	// Present one item, with a random gap first, and hold it until taken.
	// Keep valid high between back-to-back items.
	task automatic send_command(input cmd_item_t c, input bit counts = 1'b1);
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			cmd_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
		if (counts)
			items_counted++;
	endtask

	task automatic load_font(input int idx, input logic [7:0] bits);
		cmd_item_t c;
		c = random_cmd(OP_LOAD);
		c.font_index = idx[FIDX_W-1:0];
		c.font_byte = bits;
		// Loads beyond the store are dropped by the block.
		send_command(c, idx < STORE_DEPTH);
	endtask

	task automatic load_glyph(input logic [7:0] code);
		logic [7:0] bits;
		for (int i = 0; i < CHAR_WIDTH; i++) begin
			case ($urandom_range(3))
				0: bits = 8'h00;
				1: bits = 8'hFF;
				default: bits = 8'($urandom_range(255));
			endcase
			load_font(int'(code) * CHAR_WIDTH + i, bits);
		end
		if (!code_listed[code]) begin
			code_listed[code] = 1'b1;
			loaded_codes.push_back(code);
		end
	endtask

	task automatic put_char(input logic [7:0] code);
		cmd_item_t c;
		c = random_cmd(OP_CHAR);
		c.char_code = code;
		send_command(c);
	endtask

	task automatic move_cursor(input int x, input int y);
		cmd_item_t c;
		c = random_cmd(OP_CURSOR);
		c.cursor_x_in = x[COORD_W-1:0];
		c.cursor_y_in = y[COORD_W-1:0];
		send_command(c);
	endtask

	task automatic write_register(input cfg_addr_t idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Hold the sender until every expected column is out and the block has settled.
	task automatic wait_for_columns();
		cmd_valid <= 1'b0;
		// The pending count is registered, so it lags an accepted item.
		repeat (2) @(posedge clk);
		while (columns_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [15:0] fg, input logic [15:0] bg, input bit wrap,
			input int w, input int h, input int send_pct, input int stall_pct);
		int      roll;
		int      burst;
		int      idx;
		logic [7:0] ctl [3] = '{CODE_BS, CODE_LF, CODE_CR};
		cmd_item_t c;
		wait_for_columns();
		write_register(REG_FG_COLOR, fg);
		write_register(REG_BG_COLOR, bg);
		write_register(REG_WRAP_ENABLE, {15'd0, wrap});
		write_register(REG_SCREEN_WIDTH, 16'(w));
		write_register(REG_SCREEN_HEIGHT, 16'(h));
		cfg_valid <= 1'b0;
		screen_w = w;
		screen_h = h;
		sender_idle_pct = send_pct;
		receiver_stall_pct = stall_pct;

		// Print right at the right edge; at full width the columns overhang the coordinate range.
		move_cursor((w > 2) ? w - 2 : 0, 0);
		put_char(BLOCK_LO);

		items_counted = 0;
		while (items_counted < PHASE_ITEMS) begin
			roll = $urandom_range(99);
			if (loaded_codes.size() == 0 || roll < 12) begin
				load_glyph(pick_glyph_code());
			end else if (roll < 24) begin
				move_cursor(pick_coord(screen_w), pick_coord(screen_h));
			end else if (roll < 34) begin
				put_char(ctl[$urandom_range(2)]);
			end else if (roll < 39) begin
				// Noise: the unused operation or a load past the store.
				if ($urandom_range(1)) begin
					send_command(random_cmd(OP_UNUSED), 1'b0);
				end else begin
					c = random_cmd(OP_LOAD);
					c.font_index = 11'($urandom_range(2047, STORE_DEPTH));
					send_command(c, 1'b0);
				end
			end else if (roll < 43) begin
				// Overwrite a column of a glyph that is already complete.
				idx = int'(loaded_codes[$urandom_range(loaded_codes.size() - 1)]) * CHAR_WIDTH
					+ int'($urandom_range(CHAR_WIDTH - 1));
				load_font(idx, 8'($urandom_range(255)));
			end else begin
				// A run of text from the loaded glyphs.
				burst = $urandom_range(4, 1);
				repeat (burst)
					put_char(loaded_codes[$urandom_range(loaded_codes.size() - 1)]);
			end
		end
	endtask

	initial begin
		logic [15:0] shade;
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		cfg_valid = 1'b0;
		cfg_addr  = REG_FG_COLOR;
		cfg_data  = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset configuration: block graphics glyph with
		// extreme column bytes, a load past the store, saturation, control codes.
		load_font(int'(BLOCK_LO) * CHAR_WIDTH + 0, 8'hFF);
		load_font(int'(BLOCK_LO) * CHAR_WIDTH + 1, 8'h00);
		load_font(int'(BLOCK_LO) * CHAR_WIDTH + 2, 8'h80);
		load_font(int'(BLOCK_LO) * CHAR_WIDTH + 3, 8'h7F);
		load_font(int'(BLOCK_LO) * CHAR_WIDTH + 4, 8'h55);
		load_font(int'(BLOCK_LO) * CHAR_WIDTH + 5, 8'hAA);
		code_listed[BLOCK_LO] = 1'b1;
		loaded_codes.push_back(BLOCK_LO);
		load_font(2047, 8'hFF);
		put_char(BLOCK_LO);
		// Off screen at the far corner; the cursor wraps and its row saturates.
		move_cursor(1023, 1023);
		put_char(BLOCK_LO);
		put_char(CODE_LF);
		move_cursor(0, 0);
		put_char(CODE_CR);
		// Backspace at the origin clamps; near the left edge it moves up a line.
		put_char(CODE_BS);
		move_cursor(3, 30);
		put_char(CODE_BS);
		move_cursor(12, 5);
		put_char(CODE_BS);
		send_command(random_cmd(OP_UNUSED), 1'b0);
		// Step over the wrap threshold.
		move_cursor(312, 0);
		put_char(BLOCK_LO);
		put_char(BLOCK_LO);

		// Random phases over the register extremes and the idling mixes.
		run_phase(16'hFFFF, 16'h0000, 1'b1, 320, 240, 0, 0);
		run_phase(16'h0000, 16'hFFFF, 1'b0, 1023, 1023, 78, 0);
		run_phase(16'h1234, 16'h1234, 1'b1, 1, 1, 0, 78);
		run_phase(16'($urandom), 16'($urandom), 1'b1, 1023, 1023, 33, 33);
		shade = 16'($urandom);
		run_phase(shade, shade, 1'b0, 100, 50, 0, 0);
		run_phase(16'($urandom), 16'($urandom), 1'b1, int'($urandom_range(1023, 1)),
			int'($urandom_range(1023, 1)), 33, 33);

		wait_for_columns();
		if (column_failures == 0 && columns_pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/tcg_pkg.sv
sv/tcg_ctrl.sv
sv/tcg_dp.sv
sv/text_character_generator.sv
sv/tcg_checker.sv
verif/tcg_column_checker.sv
verif/tb_text_character_generator.sv
